[rtl/ldfs_pkg.sv]
// Shared types and constants for the two-wire LED display frame sender.
// No dependencies; used by the config block, the sequencer and the top level.
package ldfs_pkg;

  // APB register map (byte address = 4 * index)
  localparam int unsigned RegCount = 6;
  localparam int unsigned AddrWidth = 5;
  localparam logic [2:0] REG_DIGIT0 = 3'd0;
  localparam logic [2:0] REG_DIGIT1 = 3'd1;
  localparam logic [2:0] REG_DIGIT2 = 3'd2;
  localparam logic [2:0] REG_DIGIT3 = 3'd3;
  localparam logic [2:0] REG_BRIGHT = 3'd4;
  localparam logic [2:0] REG_ENABLE = 3'd5;

  // Command bytes
  localparam logic [7:0] CMD_DATA = 8'b0100_0000;
  localparam logic [7:0] CMD_ADDR = 8'b1100_0000;
  localparam logic [7:0] CMD_CTRL = 8'b1000_0000;

  // Transfer phases: data command, address, digits 0..3, control, idle
  localparam logic [2:0] PHASE_DATA = 3'd0;
  localparam logic [2:0] PHASE_ADDR = 3'd1;
  localparam logic [2:0] PHASE_DIG0 = 3'd2;
  localparam logic [2:0] PHASE_DIG3 = 3'd5;
  localparam logic [2:0] PHASE_CTRL = 3'd6;
  localparam logic [2:0] PHASE_IDLE = 3'd7;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [3:0][7:0] digit_segments;
    logic [2:0]      brightness_level;
    logic            display_enable;
  } cfg_t;

  // Line levels and status for one tick
  typedef struct packed {
    logic clock_pull_low;
    logic data_pull_low;
    logic busy_res;
  } line_t;

endpackage

[rtl/ldfs_if.sv]
// Valid/ready channel interfaces for the frame sender: tick input and line result.
// No dependencies.
interface ldfs_tick_if;
  logic valid;
  logic ready;
  logic start_frame;
  logic dio_sense;

  modport source (output valid, output start_frame, output dio_sense, input ready);
  modport sink (input valid, input start_frame, input dio_sense, output ready);
endinterface

interface ldfs_line_if;
  logic valid;
  logic ready;
  logic clock_pull_low;
  logic data_pull_low;
  logic busy_res;

  modport source (output valid, output clock_pull_low, output data_pull_low,
                  output busy_res, input ready);
  modport sink (input valid, input clock_pull_low, input data_pull_low,
                input busy_res, output ready);
endinterface

[rtl/ldfs_cfg.sv]
// APB register file for segment bytes, brightness and display enable.
// Depends on ldfs_pkg.
module ldfs_cfg
  import ldfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrWidth-1:2];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.digit_segments   <= '0;
      cfg.brightness_level <= 3'd7;
      cfg.display_enable   <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIGIT0: cfg.digit_segments[0] <= pwdata[7:0];
        REG_DIGIT1: cfg.digit_segments[1] <= pwdata[7:0];
        REG_DIGIT2: cfg.digit_segments[2] <= pwdata[7:0];
        REG_DIGIT3: cfg.digit_segments[3] <= pwdata[7:0];
        REG_BRIGHT: cfg.brightness_level  <= pwdata[2:0];
        REG_ENABLE: cfg.display_enable    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_DIGIT0: prdata = {24'd0, cfg.digit_segments[0]};
      REG_DIGIT1: prdata = {24'd0, cfg.digit_segments[1]};
      REG_DIGIT2: prdata = {24'd0, cfg.digit_segments[2]};
      REG_DIGIT3: prdata = {24'd0, cfg.digit_segments[3]};
      REG_BRIGHT: prdata = {29'd0, cfg.brightness_level};
      REG_ENABLE: prdata = {31'd0, cfg.display_enable};
      default:    prdata = '0;
    endcase
  end

endmodule

[rtl/ldfs_seq.sv]
// Line sequencer: transfer phase, bit step and bit counter, one line action per tick.
// Depends on ldfs_pkg.
module ldfs_seq
  import ldfs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step_en,
  input  logic  start_frame,
  input  logic  dio_sense,
  input  cfg_t  cfg,
  output line_t line_next
);

  typedef enum logic [3:0] {
    BP_START_A      = 4'd0,
    BP_START_B      = 4'd1,
    BP_BIT_DATA     = 4'd2,
    BP_BIT_CLK_UP   = 4'd3,
    BP_BIT_CLK_DOWN = 4'd4,
    BP_ACK_RELEASE  = 4'd5,
    BP_ACK_CLK_UP   = 4'd6,
    BP_ACK_POLL     = 4'd7,
    BP_ACK_CLK_DOWN = 4'd8,
    BP_STOP_CLK_UP  = 4'd9,
    BP_STOP_DATA_UP = 4'd10
  } bit_phase_t;

  logic [2:0] transfer_phase, transfer_phase_next;
  bit_phase_t bit_phase, bit_phase_next;
  logic [2:0] bit_index, bit_index_next;
  logic       clock_low_reg, clock_low_next;
  logic       data_low_reg, data_low_next;

  bit_phase_t last_step, step;
  logic       do_enter;
  logic [7:0] cur_byte;

  // Byte sent in the current transfer phase
  always_comb begin
    case (transfer_phase)
      PHASE_DATA: cur_byte = CMD_DATA;
      PHASE_ADDR: cur_byte = CMD_ADDR;
      PHASE_CTRL: cur_byte = CMD_CTRL | {4'd0, cfg.display_enable, cfg.brightness_level};
      default: begin
        if (transfer_phase >= PHASE_DIG0 && transfer_phase <= PHASE_DIG3)
          cur_byte = cfg.digit_segments[2'(transfer_phase - PHASE_DIG0)];
        else
          cur_byte = 8'd0;
      end
    endcase
  end

  // Address and digits 0..2 are chained: they end at the ack poll
  assign last_step = (transfer_phase >= PHASE_ADDR && transfer_phase < PHASE_DIG3) ?
                     BP_ACK_POLL : BP_STOP_DATA_UP;

  // Pick the step to enter this tick
  always_comb begin
    transfer_phase_next = transfer_phase;
    bit_index_next      = bit_index;
    do_enter            = 1'b0;
    step                = BP_START_A;
    if (start_frame) begin
      transfer_phase_next = PHASE_DATA;
      bit_index_next      = 3'd0;
      do_enter            = 1'b1;
      step                = BP_START_A;
    end else if (transfer_phase != PHASE_IDLE) begin
      if (bit_phase >= last_step) begin
        if (transfer_phase == PHASE_CTRL) begin
          transfer_phase_next = PHASE_IDLE;
        end else begin
          transfer_phase_next = transfer_phase + 3'd1;
          do_enter            = 1'b1;
          // Digit bytes follow on without a new start; the address and control bytes begin with one
          if (transfer_phase_next == PHASE_ADDR || transfer_phase_next == PHASE_CTRL)
            step = BP_START_A;
          else
            step = BP_START_B;
        end
      end else begin
        do_enter = 1'b1;
        step     = bit_phase_t'(bit_phase + 4'd1);
      end
    end
  end

  // Line action of the entered step
  always_comb begin
    bit_phase_next = bit_phase;
    clock_low_next = clock_low_reg;
    data_low_next  = data_low_reg;
    if (do_enter) begin
      bit_phase_next = step;
      case (step)
        BP_START_A:     data_low_next = 1'b1;
        BP_START_B:     clock_low_next = 1'b1;
        BP_BIT_DATA:    data_low_next = ~cur_byte[bit_index];
        BP_BIT_CLK_UP:  clock_low_next = 1'b0;
        BP_BIT_CLK_DOWN: begin
          clock_low_next = 1'b1;
          if (bit_index != 3'd7) begin
            bit_phase_next = BP_START_B;
          end
        end
        BP_ACK_RELEASE: data_low_next = 1'b0;
        BP_ACK_CLK_UP:  clock_low_next = 1'b0;
        BP_ACK_POLL: begin
          // Acknowledge not seen yet: poll again
          if (dio_sense)
            bit_phase_next = BP_ACK_CLK_UP;
          else
            data_low_next = 1'b1;
        end
        BP_ACK_CLK_DOWN: clock_low_next = 1'b1;
        BP_STOP_CLK_UP:  clock_low_next = 1'b0;
        BP_STOP_DATA_UP: data_low_next = 1'b0;
        default: ;
      endcase
    end
  end

  // Bit counter advances on the clock-down step, clears on the ack-release step and on a frame start
  logic [2:0] bit_index_step;
  always_comb begin
    bit_index_step = bit_index_next;
    if (do_enter && !start_frame) begin
      if (step == BP_BIT_CLK_DOWN)
        bit_index_step = bit_index + 3'd1;
      else if (step == BP_ACK_RELEASE)
        bit_index_step = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_phase <= PHASE_IDLE;
      bit_phase      <= BP_START_A;
      bit_index      <= 3'd0;
      clock_low_reg  <= 1'b0;
      data_low_reg   <= 1'b0;
    end else if (step_en) begin
      transfer_phase <= transfer_phase_next;
      bit_phase      <= bit_phase_next;
      bit_index      <= bit_index_step;
      clock_low_reg  <= clock_low_next;
      data_low_reg   <= data_low_next;
    end
  end

  assign line_next.clock_pull_low = clock_low_next;
  assign line_next.data_pull_low  = data_low_next;
  assign line_next.busy_res       = (transfer_phase_next != PHASE_IDLE);

endmodule

[rtl/led_display_two_wire_frame_sender.sv]
// Top level of the two-wire LED display frame sender: handshake and result register.
// Depends on ldfs_pkg, ldfs_if.sv, ldfs_cfg and ldfs_seq.
//
// Usage:
//   tick  - one transfer per line tick: start_frame restarts a whole frame,
//           dio_sense is the sampled data line level (acknowledge polling).
//   lines - one transfer per accepted tick: clock and data pull-low levels
//           for the open-drain lines, and busy while a frame is in progress.
//   APB   - six registers at byte addresses 0..20: four segment bytes,
//           brightness (3 bits) and display enable; writes act at once.
// Timing: an accepted tick's line levels are registered and then offered.
//   One tick per cycle is sustained while lines.ready is high; the sequencer
//   state and the result register both update in the accepting cycle.
// Stall: while a result waits unaccepted, tick.ready stays low unless the
//   result is taken in the same cycle; the sequencer does not advance.
// Reset: sequencer idle, both lines released, no result pending;
//   brightness 7, display enabled, segment bytes zero.
module led_display_two_wire_frame_sender
  import ldfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  ldfs_tick_if.sink            tick,
  ldfs_line_if.source          lines,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t  cfg;
  line_t line_next;
  line_t line_reg;
  logic  out_valid;
  logic  take_tick;

  ldfs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ldfs_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step_en     (take_tick),
    .start_frame (tick.start_frame),
    .dio_sense   (tick.dio_sense),
    .cfg         (cfg),
    .line_next   (line_next)
  );

  // Accept a tick when the result slot is free or being drained
  assign tick.ready = !out_valid || lines.ready;
  assign take_tick  = tick.valid && tick.ready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_tick) begin
      out_valid <= 1'b1;
    end else if (lines.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_tick) begin
      line_reg <= line_next;
    end
  end

  assign lines.valid          = out_valid;
  assign lines.clock_pull_low = line_reg.clock_pull_low;
  assign lines.data_pull_low  = line_reg.data_pull_low;
  assign lines.busy_res       = line_reg.busy_res;

endmodule
